// ----- src/assert_macros.svh -----
// Assertion macros shared by the face flux stencil RTL.
// No dependencies; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fcfs_pkg.sv -----
// Types, constants and fixed-point helpers for the face flux stencil.
// No dependencies; imported by every module of the block but fcfs_ram.
package fcfs_pkg;

    typedef logic signed [31:0] t_q;
    typedef logic [11:0] t_row;
    typedef logic [9:0]  t_col;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [12:0] ROWS_RST = 13'd64;
    localparam logic [10:0] COLS_RST = 11'd64;

    // restoring divider: 49 quotient bits for a 48-bit dividend plus rounding
    localparam logic [5:0] DIV_STEPS = 6'd49;

    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;

    typedef enum logic {
        FACE_EAST  = 1'b0,
        FACE_NORTH = 1'b1
    } t_dir;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_EAST,
        F_NORTH,
        F_COMMIT
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_DIV
    } t_bstate;

    // one face on its way from the front to the back
    typedef struct packed {
        t_dir dir;
        t_row row;
        t_col col;
        logic last;
        logic is_div;
        t_q   val;   // finished flux, or the boundary value to divide
        t_q   met;   // averaged metric, divisor of a boundary face
    } t_job;

    // one row buffer entry
    typedef struct packed {
        t_q   fx;
        t_q   my;
        logic flag;
        t_q   ev;
    } t_row_ent;

    // Q16.16 product: round half up, then saturate
    function automatic t_q q_rsat(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [47:0] s;
        t = p + 64'sd32768;
        s = 48'(t >>> 16);
        if (s > 48'sd2147483647) begin
            return Q_MAX;
        end else if (s < -48'sd2147483648) begin
            return Q_MIN;
        end else begin
            return t_q'(s[31:0]);
        end
    endfunction

    // average rounded half up; always fits
    function automatic t_q q_avg(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b) + 33'sd1;
        return t_q'(s[32:1]);
    endfunction

endpackage

// ----- src/fcfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

// ----- src/fcfs_queue.sv -----
// Two-entry face queue between the front and the back.
// Depends on fcfs_pkg (t_job) and assert_macros.svh.
module fcfs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcfs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output fcfs_pkg::t_job o_job,
    output logic          o_empty
);
    import fcfs_pkg::*;
    `include "assert_macros.svh"

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_push, !o_full, "face queue pushed while full")
    `ASSERT_IMPL(a_no_underflow, i_pop, !o_empty, "face queue popped while empty")
endmodule

// ----- src/fcfs_front.sv -----
// Front: takes cells, forms fluxes on one shared multiplier, keeps the row
// buffer and previous cell, and queues the east and north faces.
// Depends on fcfs_pkg.
module fcfs_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // cell channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fcfs_pkg::t_q                i_vel_x,
    input  fcfs_pkg::t_q                i_vel_y,
    input  fcfs_pkg::t_q                i_metric_x,
    input  fcfs_pkg::t_q                i_metric_y,
    input  fcfs_pkg::t_q                i_jacobian,
    input  logic                        i_east_is_boundary,
    input  logic                        i_north_is_boundary,
    input  fcfs_pkg::t_q                i_east_boundary_value,
    input  fcfs_pkg::t_q                i_north_boundary_value,
    // configuration
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_index,
    input  logic [12:0]                 i_cfg_data,
    // face queue
    output logic                        o_push,
    output fcfs_pkg::t_job              o_job,
    input  logic                        i_full,
    // row buffer
    output logic                        o_rd_en,
    output logic                        o_wr_en,
    output logic [$clog2(MAX_COLS)-1:0] o_rd_addr,
    output logic [$clog2(MAX_COLS)-1:0] o_wr_addr,
    output fcfs_pkg::t_row_ent          o_wr_data,
    input  fcfs_pkg::t_row_ent          i_rd_data
);
    import fcfs_pkg::*;

    localparam int CAW = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = (RW + 1 > 13) ? RW + 1 : 13;
    localparam int CCW = (CAW + 1 > 11) ? CAW + 1 : 11;

    t_fstate r_state, n_state;

    logic [12:0]   r_grid_rows;
    logic [10:0]   r_grid_cols;
    logic [RW-1:0] r_row;
    logic [CAW-1:0] r_col;
    logic [2:0]    r_step;

    // latched cell
    t_q   r_vx, r_vy, r_mx, r_my, r_jac, r_ev, r_nv;
    logic r_ef, r_nf;

    // multiplier path
    logic signed [63:0] r_prod;
    t_q   r_jmx, r_jmy, r_fx, r_fy;
    t_q   mul_a, mul_b;

    // previous cell
    t_q   r_prev_fy, r_prev_mx, r_prev_nv;
    logic r_prev_nf;

    logic [RCW-1:0] rows_g, eff_rows, row_x;
    logic [CCW-1:0] cols_g, eff_cols, col_x;
    logic           east_en, north_en, col_wrap, row_wrap;
    logic           accept, cfg_wr;
    t_job           east_job, north_job;

    assign accept = i_valid && o_ready;
    assign cfg_wr = i_cfg_valid;

    // clamp geometry to the supported range
    always_comb begin
        rows_g   = RCW'(r_grid_rows);
        cols_g   = CCW'(r_grid_cols);
        eff_rows = rows_g;
        eff_cols = cols_g;
        if (rows_g < RCW'(2))        eff_rows = RCW'(2);
        if (rows_g > RCW'(MAX_ROWS)) eff_rows = RCW'(MAX_ROWS);
        if (cols_g < CCW'(2))        eff_cols = CCW'(2);
        if (cols_g > CCW'(MAX_COLS)) eff_cols = CCW'(MAX_COLS);
    end

    assign row_x    = RCW'(r_row);
    assign col_x    = CCW'(r_col);
    assign east_en  = (r_row != '0) && (col_x + CCW'(1) < eff_cols);
    assign north_en = (r_col != '0) && (row_x + RCW'(1) < eff_rows);
    assign col_wrap = (col_x + CCW'(1) >= eff_cols);
    assign row_wrap = (row_x + RCW'(1) >= eff_rows);

    // multiplier operand select per step
    always_comb begin
        unique case (r_step)
            3'd0:    begin mul_a = r_jac; mul_b = r_mx; end
            3'd1:    begin mul_a = r_jac; mul_b = r_my; end
            3'd2:    begin mul_a = r_jmx; mul_b = r_vx; end
            3'd3:    begin mul_a = r_jmy; mul_b = r_vy; end
            default: begin mul_a = '0;    mul_b = '0;   end
        endcase
    end

    // east face of the cell above
    always_comb begin
        east_job.dir    = FACE_EAST;
        east_job.row    = t_row'(r_row - RW'(1));
        east_job.col    = t_col'(r_col);
        east_job.last   = (row_x == eff_rows - RCW'(1)) && (col_x == eff_cols - CCW'(2));
        east_job.is_div = i_rd_data.flag;
        east_job.val    = i_rd_data.flag ? i_rd_data.ev : q_avg(i_rd_data.fx, r_fx);
        east_job.met    = q_avg(i_rd_data.my, r_my);
    end

    // north face of the cell to the left
    always_comb begin
        north_job.dir    = FACE_NORTH;
        north_job.row    = t_row'(r_row);
        north_job.col    = t_col'(r_col - CAW'(1));
        north_job.last   = 1'b0;
        north_job.is_div = r_prev_nf;
        north_job.val    = r_prev_nf ? r_prev_nv : q_avg(r_prev_fy, r_fy);
        north_job.met    = q_avg(r_prev_mx, r_mx);
    end

    // next state and handshakes
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_job   = east_job;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = F_MUL;
            end
            F_MUL: begin
                if (r_step == 3'd4) n_state = F_EAST;
            end
            F_EAST: begin
                if (!east_en) begin
                    n_state = F_NORTH;
                end else if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_NORTH;
                end
            end
            F_NORTH: begin
                o_job = north_job;
                if (!north_en) begin
                    n_state = F_COMMIT;
                end else if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_COMMIT;
                end
            end
            F_COMMIT: n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // row buffer: read on accept, write on commit
    assign o_rd_en        = accept;
    assign o_rd_addr      = r_col;
    assign o_wr_en        = (r_state == F_COMMIT);
    assign o_wr_addr      = r_col;
    assign o_wr_data.fx   = r_fx;
    assign o_wr_data.my   = r_my;
    assign o_wr_data.flag = r_ef;
    assign o_wr_data.ev   = r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // geometry and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= ROWS_RST;
            r_grid_cols <= COLS_RST;
            r_row       <= '0;
            r_col       <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_grid_rows <= i_cfg_data;
                CFG_COLS: r_grid_cols <= i_cfg_data[10:0];
                default:  r_grid_rows <= r_grid_rows;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (r_state == F_COMMIT) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CAW'(1);
            end
        end
    end

    // previous cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_fy <= '0;
            r_prev_mx <= '0;
            r_prev_nf <= 1'b0;
            r_prev_nv <= '0;
        end else if (r_state == F_COMMIT) begin
            r_prev_fy <= r_fy;
            r_prev_mx <= r_mx;
            r_prev_nf <= r_nf;
            r_prev_nv <= r_nv;
        end
    end

    // step counter for the multiplier sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == F_MUL) begin
            r_step <= r_step + 3'd1;
        end else begin
            r_step <= '0;
        end
    end

    // cell latch and flux products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vx  <= i_vel_x;
            r_vy  <= i_vel_y;
            r_mx  <= i_metric_x;
            r_my  <= i_metric_y;
            r_jac <= i_jacobian;
            r_ef  <= i_east_is_boundary;
            r_nf  <= i_north_is_boundary;
            r_ev  <= i_east_boundary_value;
            r_nv  <= i_north_boundary_value;
        end
        if (r_state == F_MUL) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
            unique case (r_step)
                3'd1:    r_jmx <= q_rsat(r_prod);
                3'd2:    r_jmy <= q_rsat(r_prod);
                3'd3:    r_fx  <= q_rsat(r_prod);
                3'd4:    r_fy  <= q_rsat(r_prod);
                default: r_fy  <= r_fy;
            endcase
        end
    end
endmodule

// ----- src/fcfs_div.sv -----
// Boundary-face divider: value*65536/metric, rounded half away from zero,
// one quotient bit per cycle, saturating. Depends on fcfs_pkg.
module fcfs_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  fcfs_pkg::t_q i_v,
    input  fcfs_pkg::t_q i_m,
    input  logic         i_ack,
    output logic         o_done,
    output fcfs_pkg::t_q o_q
);
    import fcfs_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [48:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic        r_neg, r_zero, r_vpos, r_vzero;

    logic [31:0] v_abs, m_abs;
    logic [32:0] rem_sh;
    logic        ge;

    assign v_abs  = i_v[31] ? (~i_v + 32'd1) : i_v;
    assign m_abs  = i_m[31] ? (~i_m + 32'd1) : i_m;
    assign rem_sh = {r_rem, r_num[48]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign o_done = r_busy && (r_cnt == '0);

    // sign fix-up and saturation of the finished quotient
    always_comb begin
        if (r_zero) begin
            o_q = r_vzero ? '0 : (r_vpos ? Q_MAX : Q_MIN);
        end else if (r_neg) begin
            o_q = (r_num > 49'h0_8000_0000) ? Q_MIN : t_q'(~r_num[31:0] + 32'd1);
        end else begin
            o_q = (r_num > 49'h0_7FFF_FFFF) ? Q_MAX : t_q'(r_num[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= (i_m == '0) ? '0 : DIV_STEPS;
        end else if (o_done && i_ack) begin
            r_busy <= 1'b0;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // restoring division datapath; the remainder always stays below a nonzero divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num   <= {1'b0, v_abs, 16'd0} + {18'd0, m_abs[31:1]};
            r_den   <= m_abs;
            r_rem   <= '0;
            r_neg   <= i_v[31] ^ i_m[31];
            r_zero  <= (i_m == '0);
            r_vpos  <= !i_v[31];
            r_vzero <= (i_v == '0);
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_num <= {r_num[47:0], ge};
        end
    end
endmodule

// ----- src/fcfs_back.sv -----
// Back: takes queued faces, divides boundary faces, drives the result
// register. Depends on fcfs_pkg, fcfs_div and assert_macros.svh.
module fcfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fcfs_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_face_dir,
    output fcfs_pkg::t_row o_face_row,
    output fcfs_pkg::t_col o_face_col,
    output fcfs_pkg::t_q   o_face_flux,
    output logic           o_last_face
);
    import fcfs_pkg::*;
    `include "assert_macros.svh"

    t_bstate r_state, n_state;
    t_job    r_job;
    logic    r_out_valid;
    t_dir    r_dir;
    t_row    r_row;
    t_col    r_col;
    t_q      r_flux;
    logic    r_last;

    logic out_free, div_start, div_done, load_direct, load_div;
    t_q   div_q;

    assign out_free = !r_out_valid || i_ready;

    fcfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_v     (i_job.val),
        .i_m     (i_job.met),
        .i_ack   (load_div),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // pop, divider start and result loads
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        div_start   = 1'b0;
        load_direct = 1'b0;
        load_div    = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_job.is_div) begin
                        div_start = 1'b1;
                        n_state   = B_DIV;
                    end else begin
                        load_direct = 1'b1;
                    end
                end
            end
            B_DIV: begin
                if (div_done && out_free) begin
                    load_div = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_direct || load_div) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // face held while divided, result register
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_job <= i_job;
        end
        if (load_direct) begin
            r_dir  <= i_job.dir;
            r_row  <= i_job.row;
            r_col  <= i_job.col;
            r_last <= i_job.last;
            r_flux <= i_job.val;
        end else if (load_div) begin
            r_dir  <= r_job.dir;
            r_row  <= r_job.row;
            r_col  <= r_job.col;
            r_last <= r_job.last;
            r_flux <= div_q;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_face_dir  = r_dir;
    assign o_face_row  = r_row;
    assign o_face_col  = r_col;
    assign o_face_flux = r_flux;
    assign o_last_face = r_last;

    `ASSERT_IMPL(a_last_is_east, o_valid && o_last_face, o_face_dir == FACE_EAST,
        "last face flagged on a north face")
    `ASSERT_NEXT(a_div_holds_result, r_state == B_DIV && div_done && !out_free,
        div_done, "divider result dropped before it was taken")
endmodule

// ----- src/face_contravariant_flux_stencil_unit.sv -----
// Top level of the face flux stencil: front, face queue, back, row buffer.
// Depends on fcfs_pkg, fcfs_ram, fcfs_queue, fcfs_front and fcfs_back.
//
//  channel | handshake               | payload
//  cell    | i_valid / o_ready       | i_vel_*, i_metric_*, i_jacobian, boundary flags/values
//  face    | o_valid / i_ready       | o_face_dir, o_face_row, o_face_col, o_face_flux, o_last_face
//  config  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A cell passes through the front in order: accept, the product steps on the shared
// 32x32 multiplier, an east and a north face state that queue a face or skip it, and a row-buffer write.
// An interior face goes from the queue straight into the result register of the back; a
// boundary face first goes through the bit-serial divider.
// A full two-entry face queue or a stalled face output holds the front.
// Reset is synchronous; the row buffer is not cleared and needs no pass.
module face_contravariant_flux_stencil_unit #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fcfs_pkg::t_q   i_vel_x,
    input  fcfs_pkg::t_q   i_vel_y,
    input  fcfs_pkg::t_q   i_metric_x,
    input  fcfs_pkg::t_q   i_metric_y,
    input  fcfs_pkg::t_q   i_jacobian,
    input  logic           i_east_is_boundary,
    input  logic           i_north_is_boundary,
    input  fcfs_pkg::t_q   i_east_boundary_value,
    input  fcfs_pkg::t_q   i_north_boundary_value,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_face_dir,
    output fcfs_pkg::t_row o_face_row,
    output fcfs_pkg::t_col o_face_col,
    output fcfs_pkg::t_q   o_face_flux,
    output logic           o_last_face,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [12:0]    i_cfg_data
);
    import fcfs_pkg::*;

    localparam int CAW = $clog2(MAX_COLS);

    t_job           push_job, pop_job;
    logic           push, pop, q_full, q_empty;
    logic           rd_en, wr_en;
    logic [CAW-1:0] rd_addr, wr_addr;
    t_row_ent       wr_ent, rd_ent;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    fcfs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_vel_x                (i_vel_x),
        .i_vel_y                (i_vel_y),
        .i_metric_x             (i_metric_x),
        .i_metric_y             (i_metric_y),
        .i_jacobian             (i_jacobian),
        .i_east_is_boundary     (i_east_is_boundary),
        .i_north_is_boundary    (i_north_is_boundary),
        .i_east_boundary_value  (i_east_boundary_value),
        .i_north_boundary_value (i_north_boundary_value),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .o_push                 (push),
        .o_job                  (push_job),
        .i_full                 (q_full),
        .o_rd_en                (rd_en),
        .o_wr_en                (wr_en),
        .o_rd_addr              (rd_addr),
        .o_wr_addr              (wr_addr),
        .o_wr_data              (wr_ent),
        .i_rd_data              (rd_ent)
    );

    fcfs_ram #(
        .WIDTH ($bits(t_row_ent)),
        .DEPTH (MAX_COLS)
    ) u_row_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_ent),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_ent)
    );

    fcfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (q_empty)
    );

    fcfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_face_dir  (o_face_dir),
        .o_face_row  (o_face_row),
        .o_face_col  (o_face_col),
        .o_face_flux (o_face_flux),
        .o_last_face (o_last_face)
    );
endmodule
